// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, silenced while reset is high.
`define SB64_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SB64_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sb64_pkg.sv =====
`timescale 1ns / 1ps
// Package for the strict base64 decoder: beat types, codes, alphabet lookup.
// Depends on nothing.
package sb64_pkg;

   localparam logic       OP_CHAR          = 1'b0;
   localparam logic       OP_END           = 1'b1;
   localparam logic       KIND_DATA        = 1'b0;
   localparam logic       KIND_STATUS      = 1'b1;
   localparam logic       STATUS_OK        = 1'b0;
   localparam logic       STATUS_MALFORMED = 1'b1;
   localparam logic [7:0] CHAR_PAD         = 8'h3D;   // '='
   localparam int         COUNT_W          = 13;

   typedef struct packed {
      logic       op;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         data_byte;
      logic [COUNT_W-1:0] byte_total;
      logic               status;
      logic               run_last;
   } rsp_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // Map one character of the standard alphabet to its 6-bit value.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      r.ok    = 1'b1;
      r.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.value = 6'd62;
      end else if (c == 8'h2F) begin
         r.value = 6'd63;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== design/strict_base64_decoder.sv =====
`timescale 1ns / 1ps
// Strict base64 decoder: one character or end marker per beat in, bytes and status out.
// A result beat is offered from the output register after the input stage. Throughput:
// one input beat per cycle unless stalled; a full group drains over three byte beats,
// and a closing group or end beat waits in the input stage until the last of them is
// taken. Reset (synchronous, active high) clears the string state, empties both stages
// and sets the byte limit register to 64. Depends on sb64_pkg and assert_macros.svh.
`include "assert_macros.svh"

module strict_base64_decoder #(
   parameter int MAX_DECODED = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sb64_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sb64_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [sb64_pkg::COUNT_W-1:0] csr_wr_data
);

   localparam int CW = sb64_pkg::COUNT_W;
   // Hard cap on the limit, clipped to what the byte counter can hold.
   localparam int CapInt = (MAX_DECODED > (2 ** CW) - 1) ? (2 ** CW) - 1 : MAX_DECODED;
   localparam logic [CW-1:0] CAP = CW'(CapInt);

   // Limit register.
   logic [CW-1:0] max_bytes_ff;
   logic [CW-1:0] limit;

   // Input stage.
   logic              in_valid_ff, in_valid_in;
   sb64_pkg::req_type in_item_ff;

   // String state.
   logic [1:0]    slot_ff, slot_in;
   logic [17:0]   acc_ff, acc_in;
   logic [1:0]    pad_ff, pad_in;
   logic          padded_done_ff, padded_done_in;
   logic          err_ff, err_in;
   logic          seen_ff, seen_in;
   logic [CW-1:0] bytes_ff, bytes_in;

   // Output register: a status beat or a group of up to three byte beats.
   logic          pend_valid_ff, pend_valid_in;
   logic          pend_kind_ff, pend_kind_in;
   logic [23:0]   pend_word_ff, pend_word_in;
   logic [1:0]    pend_count_ff, pend_count_in;
   logic [CW-1:0] pend_total_ff, pend_total_in;
   logic          pend_status_ff, pend_status_in;

   // Per-item decode results.
   sb64_pkg::sextet_type sx_dec;
   logic          is_pad;
   logic          emit;
   logic          emit_status;
   logic          emit_malformed;
   logic [1:0]    emit_n;
   logic [23:0]   emit_word;
   logic          fire;
   logic          pend_take;
   logic          pend_free;
   logic [CW:0]   bytes_sum;

   assign limit = (max_bytes_ff > CAP) ? CAP : max_bytes_ff;

   // Decode the item held in the input stage against the string state.
   always_comb begin
      logic [5:0] sx;
      logic       bad;
      logic [1:0] pad_next;
      sx             = 6'd0;
      bad            = 1'b0;
      pad_next       = pad_ff;
      sx_dec         = sb64_pkg::sextet_of(in_item_ff.char_code);
      is_pad         = (in_item_ff.char_code == sb64_pkg::CHAR_PAD);
      slot_in        = slot_ff;
      acc_in         = acc_ff;
      pad_in         = pad_ff;
      padded_done_in = padded_done_ff;
      err_in         = err_ff;
      seen_in        = seen_ff;
      bytes_in       = bytes_ff;
      emit           = 1'b0;
      emit_status    = 1'b0;
      emit_malformed = 1'b0;
      emit_n         = 2'd0;
      emit_word      = {acc_ff, 6'd0};
      bytes_sum      = {1'b0, bytes_ff};

      if (in_item_ff.op == sb64_pkg::OP_END) begin
         // Report, then return the string state to its reset values.
         emit           = 1'b1;
         emit_status    = 1'b1;
         emit_n         = 2'd1;
         emit_malformed = err_ff || !seen_ff || (slot_ff != 2'd0);
         slot_in        = 2'd0;
         acc_in         = 18'd0;
         pad_in         = 2'd0;
         padded_done_in = 1'b0;
         err_in         = 1'b0;
         seen_in        = 1'b0;
         bytes_in       = '0;
      end else begin
         seen_in = 1'b1;
         if (err_ff) begin
            bad = 1'b0;   // drop silently, error already recorded
         end else if (padded_done_ff) begin
            bad = 1'b1;
         end else if (is_pad) begin
            if (slot_ff < 2'd2) begin
               bad = 1'b1;
            end else begin
               pad_next = pad_ff + 2'd1;
            end
         end else if (pad_ff != 2'd0 || !sx_dec.ok) begin
            bad = 1'b1;
         end else begin
            sx = sx_dec.value;
         end

         if (bad) begin
            err_in = 1'b1;
         end else if (!err_ff) begin
            pad_in = pad_next;
            if (slot_ff != 2'd3) begin
               acc_in  = {acc_ff[11:0], sx};
               slot_in = slot_ff + 2'd1;
            end else begin
               // Fourth character closes the group.
               emit_word = {acc_ff, sx};
               emit_n    = 2'd3 - pad_next;
               slot_in   = 2'd0;
               acc_in    = 18'd0;
               pad_in    = 2'd0;
               if (pad_next != 2'd0) begin
                  padded_done_in = 1'b1;
               end
               bytes_sum = {1'b0, bytes_ff} + (CW + 1)'(emit_n);
               if (bytes_sum > {1'b0, limit}) begin
                  err_in = 1'b1;
               end else begin
                  emit     = 1'b1;
                  bytes_in = bytes_sum[CW-1:0];
               end
            end
         end
      end
   end

   // Hold the input stage while its results cannot enter the output register.
   assign pend_take = pend_valid_ff && !rsp_stall;
   assign pend_free = !pend_valid_ff || (pend_take && pend_count_ff == 2'd1);
   assign fire      = in_valid_ff && (!emit || pend_free);
   assign req_stall = in_valid_ff && !fire;

   assign in_valid_in = (req_valid && !req_stall) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   // Output register next state: load a new run, or advance one beat.
   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_word_in   = pend_word_ff;
      pend_count_in  = pend_count_ff;
      pend_total_in  = pend_total_ff;
      pend_status_in = pend_status_ff;
      if (fire && emit) begin
         pend_valid_in = 1'b1;
         pend_count_in = emit_n;
         if (emit_status) begin
            pend_kind_in   = sb64_pkg::KIND_STATUS;
            pend_word_in   = 24'd0;
            pend_status_in = emit_malformed ? sb64_pkg::STATUS_MALFORMED
                                            : sb64_pkg::STATUS_OK;
            pend_total_in  = emit_malformed ? '0 : bytes_ff;
         end else begin
            pend_kind_in   = sb64_pkg::KIND_DATA;
            pend_word_in   = emit_word;
            pend_status_in = sb64_pkg::STATUS_OK;
            pend_total_in  = '0;
         end
      end else if (pend_take) begin
         if (pend_count_ff == 2'd1) begin
            pend_valid_in = 1'b0;
         end else begin
            pend_word_in  = {pend_word_ff[15:0], 8'd0};
            pend_count_in = pend_count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff   <= CW'(64);
         in_valid_ff    <= 1'b0;
         slot_ff        <= 2'd0;
         acc_ff         <= 18'd0;
         pad_ff         <= 2'd0;
         padded_done_ff <= 1'b0;
         err_ff         <= 1'b0;
         seen_ff        <= 1'b0;
         bytes_ff       <= '0;
         pend_valid_ff  <= 1'b0;
         pend_count_ff  <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            max_bytes_ff <= csr_wr_data;
         end
         in_valid_ff <= in_valid_in;
         if (fire) begin
            slot_ff        <= slot_in;
            acc_ff         <= acc_in;
            pad_ff         <= pad_in;
            padded_done_ff <= padded_done_in;
            err_ff         <= err_in;
            seen_ff        <= seen_in;
            bytes_ff       <= bytes_in;
         end
         pend_valid_ff <= pend_valid_in;
         pend_count_ff <= pend_count_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
      pend_kind_ff   <= pend_kind_in;
      pend_word_ff   <= pend_word_in;
      pend_total_ff  <= pend_total_in;
      pend_status_ff <= pend_status_in;
   end

   assign rsp_valid           = pend_valid_ff;
   assign rsp_data.kind       = pend_kind_ff;
   assign rsp_data.data_byte  = pend_word_ff[23:16];
   assign rsp_data.byte_total = pend_total_ff;
   assign rsp_data.status     = pend_status_ff;
   assign rsp_data.run_last   = (pend_count_ff == 2'd1);

   `SB64_ASSERT(a_pend_count, clock, reset, pend_valid_ff |-> pend_count_ff != 2'd0, "output register valid with empty run")
   `SB64_ASSERT(a_status_single, clock, reset, (pend_valid_ff && pend_kind_ff == sb64_pkg::KIND_STATUS) |-> pend_count_ff == 2'd1, "status beat not single")
   `SB64_ASSERT(a_run_continues, clock, reset, (rsp_valid && !rsp_stall && !rsp_data.run_last) |=> (rsp_valid && rsp_data.kind == sb64_pkg::KIND_DATA), "byte run broken")
   `SB64_ASSERT(a_under_limit, clock, reset, bytes_ff <= limit || $past(csr_wr_en), "byte count above limit")

endmodule
